// File: src/slfp_pkg.sv
// Package for the sorted key pool: pool size, request codes and the word types.
// Used by slfp_cell and sorted_list_in_fixed_pool_core. No dependencies.
package slfp_pkg;

  // Number of nodes in the pool, so also the number of cells in the chain.
  localparam int POOL_SIZE = 16;
  localparam int KEY_W     = 8;
  localparam int FUNC_W    = 2;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Request word.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } req_t;

  // Response word.
  typedef struct packed {
    logic found;
    logic pool_full;
  } rsp_t;

  // Token that walks down the chain of cells, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;    // search key, or the key being carried by an insert
    logic              carry;  // insert still holds a key to place
    logic              shift;  // delete has found its key and is closing the gap
    logic              found;
    logic              full;
  } token_t;

endpackage

// File: src/slfp_cell.sv
// One cell of the sorted key chain: holds one key slot and acts on the passing token.
// Depends on slfp_pkg.
module slfp_cell
  import slfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  token_t           tok_in,
  input  logic             nb_valid,
  input  logic [KEY_W-1:0] nb_key,
  output token_t           tok_out,
  output logic             held_valid,
  output logic [KEY_W-1:0] held_key
);

  token_t           tok_next;
  logic             valid_next;
  logic [KEY_W-1:0] key_next;
  logic             match;

  // The token acts on this cell's slot; the slots stay sorted and packed
  // towards the head of the chain.
  always_comb begin
    tok_next   = tok_in;
    valid_next = held_valid;
    key_next   = held_key;
    match      = held_valid && (held_key == tok_in.key);
    if (tok_in.valid) begin
      unique case (tok_in.func)
        FUNC_INSERT: begin
          // Place the carried key in an empty slot, or swap it in ahead of
          // a key that is not below it and carry the old key onwards.
          if (tok_in.carry) begin
            if (!held_valid) begin
              valid_next     = 1'b1;
              key_next       = tok_in.key;
              tok_next.carry = 1'b0;
            end else if (held_key >= tok_in.key) begin
              key_next     = tok_in.key;
              tok_next.key = held_key;
            end
          end
        end
        FUNC_DELETE: begin
          // From the first equal key onwards each slot takes its right
          // neighbour's contents, which closes the gap.
          if (tok_in.shift || match) begin
            valid_next     = nb_valid;
            key_next       = nb_key;
            tok_next.shift = 1'b1;
            if (!tok_in.shift) begin
              tok_next.found = 1'b1;
            end
          end
        end
        FUNC_QUERY: begin
          if (match) begin
            tok_next.found = 1'b1;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  // Slot occupancy and token valid are reset; the key and token payload need no reset.
  always_ff @(posedge clk) begin
    held_key      <= key_next;
    tok_out.func  <= tok_next.func;
    tok_out.key   <= tok_next.key;
    tok_out.carry <= tok_next.carry;
    tok_out.shift <= tok_next.shift;
    tok_out.found <= tok_next.found;
    tok_out.full  <= tok_next.full;
    if (rst) begin
      held_valid    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      held_valid    <= valid_next;
      tok_out.valid <= tok_next.valid;
    end
  end

endmodule

// File: src/sorted_list_in_fixed_pool_core.sv
// Sorted key pool, with the keys held in a chain of POOL_SIZE cells.
// A request's token passes through every cell in turn, then the result stage and the output register.
// Only one request is in flight at a time: a new request word is refused until the last
// response word reaches the output register; the token walks the chain one cell per cycle.
// Reset empties every cell at once; the pool is then free and a request may follow.
// Depends on slfp_pkg and slfp_cell.
module sorted_list_in_fixed_pool_core
  import slfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  token_t                 tok [POOL_SIZE+1];
  logic [POOL_SIZE-1:0]   cell_valid;
  logic [KEY_W-1:0]       cell_key [POOL_SIZE];
  logic [POOL_SIZE-1:0]   tok_live;
  logic                   busy;
  logic                   accept;
  logic                   is_insert;
  logic                   res_valid;
  rsp_t                   res;
  logic                   res_move;

  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;
  assign is_insert = (req.func == FUNC_INSERT);

  // Token launched into the head cell; a full pool turns an insert into a no-op.
  always_comb begin
    tok[0].valid = accept;
    tok[0].func  = req.func;
    tok[0].key   = req.key;
    tok[0].carry = is_insert && !cell_valid[POOL_SIZE-1];
    tok[0].shift = 1'b0;
    tok[0].found = 1'b0;
    tok[0].full  = is_insert && cell_valid[POOL_SIZE-1];
  end

  // The chain of cells; each sees its right neighbour's slot.
  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
    logic             nb_valid;
    logic [KEY_W-1:0] nb_key;
    if (i == POOL_SIZE - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_key   = '0;
    end else begin : g_body
      assign nb_valid = cell_valid[i+1];
      assign nb_key   = cell_key[i+1];
    end
    slfp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[i]),
      .nb_valid   (nb_valid),
      .nb_key     (nb_key),
      .tok_out    (tok[i+1]),
      .held_valid (cell_valid[i]),
      .held_key   (cell_key[i])
    );
    assign tok_live[i] = tok[i+1].valid;
  end

  assign res_move = res_valid && (!rsp_valid || rsp_ready);

  // Result stage and output register; busy holds until the word reaches the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (res_move) begin
        busy <= 1'b0;
      end
      if (tok[POOL_SIZE].valid) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[POOL_SIZE].valid) begin
      res.found     <= tok[POOL_SIZE].found;
      res.pool_full <= tok[POOL_SIZE].full;
    end
    if (res_move) begin
      rsp <= res;
    end
  end

  // Occupied cells always form an unbroken run from the head of the chain.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + POOL_SIZE'(1)) & cell_valid) == '0)
    else $error("occupied cells are not packed towards the head");

  // No token walks the chain while the block is idle.
  a_idle_chain: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (tok_live == '0))
    else $error("token in the chain while idle");

  // At most one token is in the chain at any time.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_live))
    else $error("more than one token in the chain");

  // A response never reports both a found key and a full pool.
  a_rsp_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.found && rsp.pool_full))
    else $error("response reports found and pool full together");

endmodule
